// ===== rtl/core/obue_pkg.sv =====
// Shared types, sizes and codes for the order book update engine.
// No dependencies.
package obue_pkg;

    localparam int ORDER_SLOTS = 4096;
    localparam int LEVEL_SLOTS = 1024;
    localparam int OA_W = $clog2(ORDER_SLOTS);
    localparam int LA_W = $clog2(LEVEL_SLOTS);
    localparam int MAX_SLOTS = (ORDER_SLOTS > LEVEL_SLOTS) ? ORDER_SLOTS : LEVEL_SLOTS;
    localparam int SC_W = $clog2(MAX_SLOTS) + 1;
    localparam int SUM_W = 40;

    localparam logic [7:0] ACT_ADD    = 8'd1;
    localparam logic [7:0] ACT_CANCEL = 8'd2;
    localparam logic [7:0] ACT_DELETE = 8'd3;
    localparam logic [7:0] ACT_EXEC   = 8'd4;
    localparam logic [7:0] ACT_IGNORE = 8'd7;

    localparam logic [2:0] ST_DONE       = 3'd0;
    localparam logic [2:0] ST_IGNORED    = 3'd1;
    localparam logic [2:0] ST_UNKNOWN    = 3'd2;
    localparam logic [2:0] ST_MISSING    = 3'd3;
    localparam logic [2:0] ST_ORDER_FULL = 3'd4;
    localparam logic [2:0] ST_DUPLICATE  = 3'd5;
    localparam logic [2:0] ST_LEVEL_FULL = 3'd6;

    typedef struct packed {
        logic        valid;
        logic [63:0] key;
        logic [32:0] place;
        logic [31:0] remaining;
    } order_entry_t;

    typedef struct packed {
        logic             valid;
        logic [32:0]      key;
        logic [SUM_W-1:0] sum;
    } level_entry_t;

endpackage

// ===== rtl/core/order_book_update_engine.sv =====
// Order book update engine: order table and price-level table in block memory.
// An add, cancel, delete or execute scans the order table and, if it goes on, the
// level table, one entry a cycle, then writes entries back. Depends on obue_pkg.
//
// The time an add, cancel, delete or execute takes is set by the linear search of each
// table through its single read port; a missing id, a duplicate id or a full order
// table ends after the order scan. Type 7 and unknown types skip both scans. After
// reset the block runs a clearing pass over both tables before in_ready rises.
// One message is in work at a time; the result sits in an output register, so the
// next word is taken while an earlier result still waits.
module order_book_update_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  action,
    input  logic [63:0] msg_ref,
    input  logic        side,
    input  logic [31:0] price,
    input  logic [31:0] quantity,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic        order_removed,
    output logic        level_side,
    output logic [31:0] level_price,
    output logic [obue_pkg::SUM_W-1:0] level_total
);
    import obue_pkg::*;

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_OSCAN = 3'd2;
    localparam logic [2:0] S_LSCAN = 3'd3;
    localparam logic [2:0] S_UPD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    order_entry_t o_mem [ORDER_SLOTS];
    level_entry_t l_mem [LEVEL_SLOTS];
    order_entry_t o_rdata, o_wdata;
    level_entry_t l_rdata, l_wdata;
    logic o_we, l_we;
    logic [OA_W-1:0] o_waddr;
    logic [LA_W-1:0] l_waddr;

    logic [2:0] state_reg, state_next;
    logic [SC_W-1:0] issue_reg, issue_next, pidx_reg, pidx_next;
    logic pend_reg, pend_next;

    logic [7:0] act_reg, act_next;
    logic [63:0] id_reg, id_next;
    logic [32:0] place_reg, place_next;
    logic [31:0] qty_reg, qty_next;

    logic o_hit_reg, o_hit_next, o_free_reg, o_free_next;
    logic [OA_W-1:0] o_hidx_reg, o_hidx_next, o_fidx_reg, o_fidx_next;
    logic [32:0] o_place_reg, o_place_next;
    logic [31:0] o_rem_reg, o_rem_next;
    logic l_hit_reg, l_hit_next, l_free_reg, l_free_next;
    logic [LA_W-1:0] l_hidx_reg, l_hidx_next, l_fidx_reg, l_fidx_next;
    logic [SUM_W-1:0] l_sum_reg, l_sum_next;

    logic [2:0] res_st_reg, res_st_next;
    logic res_rm_reg, res_rm_next;
    logic [32:0] res_pl_reg, res_pl_next;
    logic [SUM_W-1:0] res_tot_reg, res_tot_next;

    logic out_valid_reg, out_valid_next;
    logic [2:0] st_out_reg;
    logic rm_out_reg;
    logic [32:0] pl_out_reg;
    logic [SUM_W-1:0] tot_out_reg;

    logic [32:0] lkey;
    logic [31:0] amt, rem_new;
    logic [SUM_W:0] add_sum;
    logic [SUM_W-1:0] sat_sum, sub_sum;
    logic is_add;

    always_ff @(posedge clk)
    begin
        if (o_we)
        begin
            o_mem[o_waddr] <= o_wdata;
        end
        o_rdata <= o_mem[issue_reg[OA_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (l_we)
        begin
            l_mem[l_waddr] <= l_wdata;
        end
        l_rdata <= l_mem[issue_reg[LA_W-1:0]];
    end

    assign is_add  = (act_reg == ACT_ADD);
    assign lkey    = is_add ? place_reg : o_place_reg;
    assign amt     = (act_reg == ACT_DELETE) ? o_rem_reg :
                     ((qty_reg < o_rem_reg) ? qty_reg : o_rem_reg);
    assign rem_new = o_rem_reg - amt;
    assign add_sum = {1'b0, (l_hit_reg ? l_sum_reg : {SUM_W{1'b0}})}
                     + {{(SUM_W - 31){1'b0}}, qty_reg};
    assign sat_sum = add_sum[SUM_W] ? {SUM_W{1'b1}} : add_sum[SUM_W-1:0];
    assign sub_sum = (l_sum_reg > {{(SUM_W - 32){1'b0}}, amt})
                     ? l_sum_reg - {{(SUM_W - 32){1'b0}}, amt} : {SUM_W{1'b0}};

    always_comb
    begin
        state_next   = state_reg;
        issue_next   = issue_reg;
        pend_next    = 1'b0;
        pidx_next    = issue_reg;
        act_next     = act_reg;
        id_next      = id_reg;
        place_next   = place_reg;
        qty_next     = qty_reg;
        o_hit_next   = o_hit_reg;
        o_free_next  = o_free_reg;
        o_hidx_next  = o_hidx_reg;
        o_fidx_next  = o_fidx_reg;
        o_place_next = o_place_reg;
        o_rem_next   = o_rem_reg;
        l_hit_next   = l_hit_reg;
        l_free_next  = l_free_reg;
        l_hidx_next  = l_hidx_reg;
        l_fidx_next  = l_fidx_reg;
        l_sum_next   = l_sum_reg;
        res_st_next  = res_st_reg;
        res_rm_next  = res_rm_reg;
        res_pl_next  = res_pl_reg;
        res_tot_next = res_tot_reg;
        o_we    = 1'b0;
        l_we    = 1'b0;
        o_waddr = issue_reg[OA_W-1:0];
        l_waddr = issue_reg[LA_W-1:0];
        o_wdata = '0;
        l_wdata = '0;

        case (state_reg)
            S_CLR:
            begin
                o_we = (issue_reg < SC_W'(ORDER_SLOTS));
                l_we = (issue_reg < SC_W'(LEVEL_SLOTS));
                issue_next = issue_reg + SC_W'(1);
                if (issue_reg == SC_W'(MAX_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                issue_next = '0;
                if (in_valid)
                begin
                    act_next    = action;
                    id_next     = msg_ref;
                    place_next  = {side, price};
                    qty_next    = quantity;
                    o_hit_next  = 1'b0;
                    o_free_next = 1'b0;
                    l_hit_next  = 1'b0;
                    l_free_next = 1'b0;
                    res_rm_next = 1'b0;
                    res_pl_next = '0;
                    res_tot_next = '0;
                    if (action == ACT_ADD || action == ACT_CANCEL ||
                        action == ACT_DELETE || action == ACT_EXEC)
                    begin
                        state_next = S_OSCAN;
                    end
                    else
                    begin
                        res_st_next = (action == ACT_IGNORE) ? ST_IGNORED : ST_UNKNOWN;
                        state_next  = S_OUT;
                    end
                end
            end
            S_OSCAN:
            begin
                if (issue_reg < SC_W'(ORDER_SLOTS))
                begin
                    issue_next = issue_reg + SC_W'(1);
                    pend_next  = 1'b1;
                end
                if (pend_reg)
                begin
                    if (o_rdata.valid && o_rdata.key == id_reg && !o_hit_reg)
                    begin
                        o_hit_next   = 1'b1;
                        o_hidx_next  = pidx_reg[OA_W-1:0];
                        o_place_next = o_rdata.place;
                        o_rem_next   = o_rdata.remaining;
                    end
                    if (!o_rdata.valid && !o_free_reg)
                    begin
                        o_free_next = 1'b1;
                        o_fidx_next = pidx_reg[OA_W-1:0];
                    end
                end
                else if (issue_reg == SC_W'(ORDER_SLOTS))
                begin
                    issue_next = '0;
                    if (is_add && o_hit_reg)
                    begin
                        res_st_next = ST_DUPLICATE;
                        state_next  = S_OUT;
                    end
                    else if (is_add && !o_free_reg)
                    begin
                        res_st_next = ST_ORDER_FULL;
                        state_next  = S_OUT;
                    end
                    else if (!is_add && !o_hit_reg)
                    begin
                        res_st_next = ST_MISSING;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        state_next = S_LSCAN;
                    end
                end
            end
            S_LSCAN:
            begin
                if (issue_reg < SC_W'(LEVEL_SLOTS))
                begin
                    issue_next = issue_reg + SC_W'(1);
                    pend_next  = 1'b1;
                end
                if (pend_reg)
                begin
                    if (l_rdata.valid && l_rdata.key == lkey && !l_hit_reg)
                    begin
                        l_hit_next  = 1'b1;
                        l_hidx_next = pidx_reg[LA_W-1:0];
                        l_sum_next  = l_rdata.sum;
                    end
                    if (!l_rdata.valid && !l_free_reg)
                    begin
                        l_free_next = 1'b1;
                        l_fidx_next = pidx_reg[LA_W-1:0];
                    end
                end
                else if (issue_reg == SC_W'(LEVEL_SLOTS))
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                state_next = S_OUT;
                if (is_add)
                begin
                    if (!l_hit_reg && !l_free_reg)
                    begin
                        res_st_next = ST_LEVEL_FULL;
                    end
                    else
                    begin
                        o_we    = 1'b1;
                        o_waddr = o_fidx_reg;
                        o_wdata = '{valid: 1'b1, key: id_reg, place: place_reg,
                                    remaining: qty_reg};
                        l_we    = 1'b1;
                        l_waddr = l_hit_reg ? l_hidx_reg : l_fidx_reg;
                        l_wdata = '{valid: 1'b1, key: place_reg, sum: sat_sum};
                        res_st_next  = ST_DONE;
                        res_pl_next  = place_reg;
                        res_tot_next = sat_sum;
                    end
                end
                else
                begin
                    o_we    = 1'b1;
                    o_waddr = o_hidx_reg;
                    o_wdata = '{valid: (rem_new != 32'd0), key: id_reg, place: o_place_reg,
                                remaining: rem_new};
                    l_we    = l_hit_reg;
                    l_waddr = l_hidx_reg;
                    l_wdata = '{valid: (sub_sum != '0), key: o_place_reg, sum: sub_sum};
                    res_st_next  = ST_DONE;
                    res_rm_next  = (rem_new == 32'd0);
                    res_pl_next  = o_place_reg;
                    res_tot_next = l_hit_reg ? sub_sum : '0;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == S_OUT && (!out_valid_reg || out_ready))
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg    <= pidx_next;
        act_reg     <= act_next;
        id_reg      <= id_next;
        place_reg   <= place_next;
        qty_reg     <= qty_next;
        o_hit_reg   <= o_hit_next;
        o_free_reg  <= o_free_next;
        o_hidx_reg  <= o_hidx_next;
        o_fidx_reg  <= o_fidx_next;
        o_place_reg <= o_place_next;
        o_rem_reg   <= o_rem_next;
        l_hit_reg   <= l_hit_next;
        l_free_reg  <= l_free_next;
        l_hidx_reg  <= l_hidx_next;
        l_fidx_reg  <= l_fidx_next;
        l_sum_reg   <= l_sum_next;
        res_st_reg  <= res_st_next;
        res_rm_reg  <= res_rm_next;
        res_pl_reg  <= res_pl_next;
        res_tot_reg <= res_tot_next;
        if (state_reg == S_OUT && (!out_valid_reg || out_ready))
        begin
            st_out_reg  <= res_st_reg;
            rm_out_reg  <= res_rm_reg;
            pl_out_reg  <= res_pl_reg;
            tot_out_reg <= res_tot_reg;
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = st_out_reg;
    assign order_removed = rm_out_reg;
    assign level_side    = pl_out_reg[32];
    assign level_price   = pl_out_reg[31:0];
    assign level_total   = tot_out_reg;

endmodule

// ===== rtl/core/obue_checker.sv =====
// Port-level checks for the order book update engine, bound to the top level.
// Depends on obue_pkg.
module obue_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic        order_removed,
    input logic        level_side,
    input logic [31:0] level_price,
    input logic [obue_pkg::SUM_W-1:0] level_total
);
    import obue_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(level_total))
        else $error("result word changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken while one is in work");

    a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DONE |-> !order_removed && !level_side &&
        level_price == 32'd0 && level_total == '0)
        else $error("fault result carries level data");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_LEVEL_FULL)
        else $error("status out of range");

    a_removed_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && order_removed |-> status == ST_DONE)
        else $error("removal flagged on a fault");

endmodule

bind order_book_update_engine obue_checker u_obue_checker (.*);
